/* rtl/wsm_pkg.sv */
// wsm_pkg: field widths, register indexes and the command/status types
// shared by the weighted stripe mapper controller, datapath and top level
// no dependencies
`default_nettype none

package wsm_pkg;

  localparam int OFS_W      = 48;
  localparam int LEN_W      = 48;
  localparam int BS_W       = 32;
  localparam int SC_W       = 4;
  localparam int WT_W       = 64;
  localparam int WGT_W      = 8;
  localparam int NUM_SLOTS  = 8;
  localparam int SUM_W      = 11;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_BLK_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TABLE = 2'd2;

  localparam logic [BS_W-1:0] BLK_BYTES_RST    = 32'd65536;
  localparam logic [SC_W-1:0] SERVER_COUNT_RST = 4'd8;

  typedef struct packed {
    logic load;
    logic div_step;
    logic walk_step;
    logic mul_w;
    logic mul_lo;
    logic mul_hi;
    logic out_load;
  } wsm_cmd_t;

  typedef struct packed {
    logic skip;
    logic found;
  } wsm_sts_t;

endpackage

`default_nettype wire

/* rtl/weighted_stripe_mapper.sv */
// Weighted stripe mapper. One beat in gives a byte offset and the bytes
// still to place; one beat out gives the server, chunk length (cut at the
// end of the block), offset on that server and global block number. An item
// is taken only while the block is idle. A shared shift-subtract loop makes
// one bit of offset over the block size and of block/weight_sum each cycle
// over the low W bits of offset (W the lesser of OFFSET_BITS and 48), then
// the weight walk visits one server per cycle and a split multiplier forms
// the server offset from a weight product and two half products. A zero
// length, weight sum or block size skips from the division to the result.
// The result sits in an output register, so the next beat is taken while
// it waits. Depends on wsm_pkg, wsm_ctrl and wsm_dp.
`default_nettype none

module weighted_stripe_mapper
  import wsm_pkg::*;
#(
  parameter int MAX_SERVERS = 8,
  parameter int OFFSET_BITS = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [OFS_W-1:0]      in_byte_offset,
  input  wire logic [LEN_W-1:0]      in_remaining_length,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_chunk_valid,
  output logic                       out_weight_error,
  output logic [IDX_W-1:0]           out_server_index,
  output logic [BS_W-1:0]            out_chunk_length,
  output logic [OFS_W-1:0]           out_server_offset,
  output logic [OFS_W-1:0]           out_block_number
);

  localparam int OW = (OFFSET_BITS < OFS_W) ? OFFSET_BITS : OFS_W;

  wsm_cmd_t cmd;
  wsm_sts_t sts;

  wsm_ctrl #(
    .DIV_STEPS (OW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  wsm_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .OW          (OW)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_byte_offset      (in_byte_offset),
    .in_remaining_length (in_remaining_length),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_chunk_valid     (out_chunk_valid),
    .out_weight_error    (out_weight_error),
    .out_server_index    (out_server_index),
    .out_chunk_length    (out_chunk_length),
    .out_server_offset   (out_server_offset),
    .out_block_number    (out_block_number)
  );

endmodule

`default_nettype wire

/* rtl/wsm_ctrl.sv */
// wsm_ctrl: sequencer for the weighted stripe mapper
// drives datapath commands from datapath status; uses wsm_pkg
`default_nettype none

module wsm_ctrl
  import wsm_pkg::*;
#(
  parameter int DIV_STEPS = 48
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output wsm_cmd_t      cmd,
  input  wire wsm_sts_t sts
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_MULW  = 3'd3;
  localparam logic [2:0] S_MULLO = 3'd4;
  localparam logic [2:0] S_MULHI = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.skip) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (sts.found) begin
          state_nxt = S_MULW;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_MULW: begin
        cmd.mul_w = 1'b1;
        state_nxt = S_MULLO;
      end
      S_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MULHI;
      end
      S_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while a beat is pending");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.walk_step, cmd.mul_w, cmd.mul_lo,
              cmd.mul_hi, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_load_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DIV))
    else $error("accepted beat did not start the division");

  a_skip_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.skip) |=> (state_r == S_FIN && !cmd.div_step))
    else $error("empty item did not go straight to the result");
`endif

endmodule

`default_nettype wire

/* rtl/wsm_dp.sv */
// wsm_dp: datapath of the weighted stripe mapper: config registers, chained
// bit-serial dividers, weight walk, split multiplier and result register; uses wsm_pkg
`default_nettype none

module wsm_dp
  import wsm_pkg::*;
#(
  parameter int MAX_SERVERS = 8,
  parameter int OW          = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [OFS_W-1:0]      in_byte_offset,
  input  wire logic [LEN_W-1:0]      in_remaining_length,
  input  wire wsm_cmd_t              cmd,
  output wsm_sts_t                   sts,
  output logic                       out_chunk_valid,
  output logic                       out_weight_error,
  output logic [IDX_W-1:0]           out_server_index,
  output logic [BS_W-1:0]            out_chunk_length,
  output logic [OFS_W-1:0]           out_server_offset,
  output logic [OFS_W-1:0]           out_block_number
);

  localparam int HALF = (OW + 1) / 2;
  localparam int HW   = OW - HALF;

  logic [BS_W-1:0]  blk_bytes_r;
  logic [SC_W-1:0]  server_count_r;
  logic [WT_W-1:0]  weight_table_r;

  logic [SC_W-1:0]  active_c;
  logic [SUM_W-1:0] sum_c;
  logic [SUM_W-1:0] sum_r;
  logic [LEN_W-1:0] length_r;

  logic [OW-1:0]    quo1_r;
  logic [BS_W-1:0]  rem1_r;
  logic [OW-1:0]    round_r;
  logic [SUM_W-1:0] rem2_r;
  logic [IDX_W-1:0] idx_r;
  logic [OW-1:0]    t1_r;
  logic [OW-1:0]    acc_r;

  logic [BS_W:0]      trial1;
  logic               ge1;
  logic [BS_W:0]      diff1;
  logic [SUM_W:0]     trial2;
  logic               ge2;
  logic [SUM_W:0]     diff2;
  logic [WGT_W-1:0]   wt_sel;
  logic [OW+WGT_W-1:0] prod_w;
  logic [HALF+BS_W-1:0] prod_lo;
  logic [HW+BS_W-1:0]   prod_hi;
  logic [BS_W-1:0]    room;
  logic [BS_W-1:0]    len_c;
  logic [OW-1:0]      pos_c;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_bytes_r    <= BLK_BYTES_RST;
      server_count_r <= SERVER_COUNT_RST;
      weight_table_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLK_BYTES:    blk_bytes_r    <= cfg_data[BS_W-1:0];
        CFG_SERVER_COUNT: server_count_r <= cfg_data[SC_W-1:0];
        CFG_WEIGHT_TABLE: weight_table_r <= cfg_data[WT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sum of active weights
  assign active_c = (server_count_r > SC_W'(MAX_SERVERS)) ? SC_W'(MAX_SERVERS)
                                                          : server_count_r;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (SC_W'(i) < active_c) begin
        sum_c = sum_c + SUM_W'(weight_table_r[i*WGT_W +: WGT_W]);
      end
    end
  end

  // offset / block bytes feeding block / sum one quotient bit per cycle
  assign trial1 = {rem1_r, quo1_r[OW-1]};
  assign ge1    = (trial1 >= {1'b0, blk_bytes_r});
  assign diff1  = trial1 - {1'b0, blk_bytes_r};
  assign trial2 = {rem2_r, ge1};
  assign ge2    = (trial2 >= {1'b0, sum_r});
  assign diff2  = trial2 - {1'b0, sum_r};

  assign wt_sel = weight_table_r[{idx_r, 3'b000} +: WGT_W];

  assign prod_w  = round_r * wt_sel;
  assign prod_lo = t1_r[HALF-1:0] * blk_bytes_r;
  assign prod_hi = t1_r[OW-1:HALF] * blk_bytes_r;

  assign sts.skip  = (length_r == '0) || (sum_r == '0) || (blk_bytes_r == '0);
  assign sts.found = (rem2_r < SUM_W'(wt_sel));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_r    <= sum_c;
      length_r <= in_remaining_length;
      quo1_r   <= in_byte_offset[OW-1:0];
      rem1_r   <= '0;
      round_r  <= '0;
      rem2_r   <= '0;
      idx_r    <= '0;
    end
    if (cmd.div_step) begin
      quo1_r  <= {quo1_r[OW-2:0], ge1};
      rem1_r  <= ge1 ? diff1[BS_W-1:0] : trial1[BS_W-1:0];
      round_r <= {round_r[OW-2:0], ge2};
      rem2_r  <= ge2 ? diff2[SUM_W-1:0] : trial2[SUM_W-1:0];
    end
    if (cmd.walk_step) begin
      rem2_r <= rem2_r - SUM_W'(wt_sel);
      idx_r  <= idx_r + 1'b1;
    end
    if (cmd.mul_w) begin
      t1_r <= prod_w[OW-1:0] + OW'(rem2_r);
    end
    if (cmd.mul_lo) begin
      acc_r <= prod_lo[OW-1:0];
    end
    if (cmd.mul_hi) begin
      acc_r <= acc_r + {prod_hi[HW-1:0], {HALF{1'b0}}};
    end
  end

  // chunk length and final position
  assign room  = blk_bytes_r - rem1_r;
  assign len_c = (length_r < LEN_W'(room)) ? length_r[BS_W-1:0] : room;
  assign pos_c = acc_r + OW'(rem1_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_weight_error <= (sum_r == '0);
      if (sts.skip) begin
        out_chunk_valid   <= 1'b0;
        out_server_index  <= '0;
        out_chunk_length  <= '0;
        out_server_offset <= '0;
        out_block_number  <= '0;
      end else begin
        out_chunk_valid   <= 1'b1;
        out_server_index  <= idx_r;
        out_chunk_length  <= len_c;
        out_server_offset <= OFS_W'(pos_c);
        out_block_number  <= OFS_W'(quo1_r);
      end
    end
  end

endmodule

`default_nettype wire

/* tb/weighted_stripe_mapper_tb.sv */
// weighted_stripe_mapper_tb: self-checking bench for the weighted stripe mapper,
// predicting each chunk from a local copy of the registers and scoring every beat
// depends on wsm_pkg and weighted_stripe_mapper
`default_nettype none

module weighted_stripe_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 13;
  localparam int PHASE_ITEMS    = 100;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 500;

  typedef struct packed {
    logic [OFS_W-1:0] ofs;
    logic [LEN_W-1:0] len;
  } span_t;

  typedef struct packed {
    logic             chunk_valid;
    logic             weight_error;
    logic [IDX_W-1:0] server_index;
    logic [BS_W-1:0]  chunk_length;
    logic [OFS_W-1:0] server_offset;
    logic [OFS_W-1:0] block_number;
  } chunk_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OFS_W-1:0]      in_byte_offset = '0;
  logic [LEN_W-1:0]      in_remaining_length = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_chunk_valid;
  logic                  out_weight_error;
  logic [IDX_W-1:0]      out_server_index;
  logic [BS_W-1:0]       out_chunk_length;
  logic [OFS_W-1:0]      out_server_offset;
  logic [OFS_W-1:0]      out_block_number;

  logic [BS_W-1:0] cur_bs = BLK_BYTES_RST;
  logic [SC_W-1:0] cur_sc = SERVER_COUNT_RST;
  logic [WT_W-1:0] cur_wt = '0;

  span_t  spans_pending[$];
  chunk_t chunks_due[$];
  span_t  next_span;

  logic        in_taken = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          beats_in = 0;
  int          chunks_out = 0;
  int          weight_errs_out = 0;
  int          quiet_cycles = 0;
  int          mismatches = 0;
  int          setups = 0;

  weighted_stripe_mapper DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic chunk_t map_chunk(input logic [OFS_W-1:0] ofs,
                                       input logic [LEN_W-1:0] len);
    chunk_t           res;
    logic [63:0]      bs, blk, disp, stripe_round, rest, room, pos, total, w, srv_w;
    int               active;
    logic [IDX_W-1:0] srv;
    logic             found;
    res = '0;
    active = (cur_sc > NUM_SLOTS) ? NUM_SLOTS : int'(cur_sc);
    total = '0;
    for (int i = 0; i < active; i++) total += 64'(cur_wt[8*i +: 8]);
    res.weight_error = (total == 0);
    if (len != 0 && total != 0 && cur_bs != 0) begin
      bs = 64'(cur_bs);
      blk = 64'(ofs) / bs;
      disp = 64'(ofs) % bs;
      stripe_round = blk / total;
      rest = blk % total;
      srv = '0;
      found = 1'b0;
      // zero weight servers fall through the walk
      for (int i = 0; i < active; i++) begin
        w = 64'(cur_wt[8*i +: 8]);
        if (!found) begin
          if (rest < w) begin
            srv = IDX_W'(i);
            found = 1'b1;
          end else begin
            rest -= w;
          end
        end
      end
      srv_w = 64'(cur_wt[8*srv +: 8]);
      room = bs - disp;
      pos = (stripe_round * srv_w + rest) * bs + disp;
      res.chunk_valid = 1'b1;
      res.server_index = srv;
      res.chunk_length = (64'(len) < room) ? len[BS_W-1:0] : room[BS_W-1:0];
      res.server_offset = pos[OFS_W-1:0];
      res.block_number = blk[OFS_W-1:0];
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_span(input logic [OFS_W-1:0] ofs, input logic [LEN_W-1:0] len);
    spans_pending.push_back(span_t'{ofs, len});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_BLK_BYTES:    cur_bs = val[BS_W-1:0];
      CFG_SERVER_COUNT: cur_sc = val[SC_W-1:0];
      CFG_WEIGHT_TABLE: cur_wt = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (spans_pending.size() != 0 || in_valid || chunks_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    setups++;
  endtask

  // sender: bursts with random gaps
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left > 0 || spans_pending.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        next_span = spans_pending.pop_front();
        in_valid <= 1'b1;
        in_byte_offset <= next_span.ofs;
        in_remaining_length <= next_span.len;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall patterns plus one long hold-off while the sender keeps going
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= HOLD_AFTER && spans_pending.size() > 20) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        READY_ALWAYS:   out_ready <= 1'b1;
        READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
        READY_PERIODIC: out_ready <= (mode_left % 6) < 2;
        default:        out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor, scoreboard and watchdog
  chunk_t due;
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        chunks_due.push_back(map_chunk(in_byte_offset, in_remaining_length));
        beats_in <= beats_in + 1;
      end
      if (out_valid && out_ready) begin
        if (chunks_due.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, block_number 0x%0h",
                   $time, out_block_number);
          mismatches++;
        end else begin
          due = chunks_due.pop_front();
          check_field("chunk_valid", 64'(due.chunk_valid), 64'(out_chunk_valid));
          check_field("weight_error", 64'(due.weight_error), 64'(out_weight_error));
          check_field("server_index", 64'(due.server_index), 64'(out_server_index));
          check_field("chunk_length", 64'(due.chunk_length), 64'(out_chunk_length));
          check_field("server_offset", 64'(due.server_offset), 64'(out_server_offset));
          check_field("block_number", 64'(due.block_number), 64'(out_block_number));
          if (due.chunk_valid) chunks_out <= chunks_out + 1;
          if (due.weight_error) weight_errs_out <= weight_errs_out + 1;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    span_t       s;
    chunk_t      c;
    logic [63:0] wt, lim, tmp;
    logic [31:0] bs_pick;
    logic [3:0]  sc_pick;
    int          n, steps;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings carry no weights
    add_span(48'h1000, 48'd64);
    add_span(48'h0, 48'd0);
    drain();

    write_reg(CFG_BLK_BYTES, 64'd16);
    write_reg(CFG_SERVER_COUNT, 64'd4);
    write_reg(CFG_WEIGHT_TABLE, 64'hFFFF_FFFF_0203_0001);
    add_span(48'd0, 48'd1);
    add_span(48'd15, 48'd100);
    for (int k = 1; k <= 5; k++) add_span(48'(16 * k), 48'd16);
    add_span(48'd208, 48'd5);
    add_span('1, '1);
    add_span(48'd33, 48'd0);
    drain();

    // widest block, saturated server count, full weights
    write_reg(CFG_BLK_BYTES, 64'hFFFF_FFFF);
    write_reg(CFG_SERVER_COUNT, 64'd15);
    write_reg(CFG_WEIGHT_TABLE, '1);
    add_span('1, '1);
    add_span(48'd0, '1);
    add_span(48'hFFFF_FFFE, 48'd7);
    drain();

    write_reg(CFG_BLK_BYTES, 64'd0);
    add_span(48'h1234, 48'd10);
    drain();

    write_reg(CFG_BLK_BYTES, 64'd4096);
    write_reg(CFG_SERVER_COUNT, 64'd0);
    add_span(48'h1234, 48'd10);
    drain();

    write_reg(CFG_BLK_BYTES, 64'd1);
    write_reg(CFG_SERVER_COUNT, 64'd1);
    write_reg(CFG_WEIGHT_TABLE, 64'd1);
    add_span('1, '1);
    add_span(48'd12345, 48'd1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: bs_pick = 32'd1;
        1: bs_pick = $urandom_range(1, 64);
        2: bs_pick = 32'd1 << $urandom_range(4, 31);
        3: bs_pick = $urandom;
        4: bs_pick = 32'hFFFF_FFFF;
        default: bs_pick = $urandom_range(100, 100000);
      endcase
      sc_pick = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 8))
                                            : 4'($urandom_range(0, 15));
      wt = '0;
      for (int b = 0; b < 8; b++) begin
        case ($urandom_range(0, 3))
          0: wt[8*b +: 8] = 8'd0;
          1: wt[8*b +: 8] = 8'($urandom_range(1, 3));
          2: wt[8*b +: 8] = 8'($urandom);
          default: wt[8*b +: 8] = 8'hFF;
        endcase
      end
      write_reg(CFG_WEIGHT_TABLE, wt);
      write_reg(CFG_SERVER_COUNT, 64'(sc_pick));
      write_reg(CFG_BLK_BYTES, 64'(bs_pick));

      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 2) == 0 && cur_bs != 0) begin
          // walk a range the way a caller would, chunk by chunk
          s.ofs = 48'({$urandom, $urandom});
          lim = 64'(cur_bs) * 6;
          s.len = 48'(({$urandom, $urandom} % lim) + 1);
          steps = 0;
          c = '0;
          c.chunk_valid = 1'b1;
          while (steps < 10 && c.chunk_valid) begin
            add_span(s.ofs, s.len);
            n++;
            steps++;
            c = map_chunk(s.ofs, s.len);
            s.ofs = s.ofs + 48'(c.chunk_length);
            s.len = s.len - 48'(c.chunk_length);
          end
        end else begin
          case ($urandom_range(0, 7))
            0, 1: begin
              s.ofs = 48'({$urandom, $urandom});
              s.len = 48'({$urandom, $urandom});
            end
            2: begin
              s.ofs = 48'($urandom_range(0, 4096));
              s.len = 48'($urandom_range(1, 64));
            end
            3, 4: begin
              tmp = 64'(48'({$urandom, $urandom}));
              if (cur_bs != 0)
                tmp = tmp - tmp % 64'(cur_bs) + 64'(cur_bs) - 64'($urandom_range(1, 8));
              s.ofs = tmp[OFS_W-1:0];
              s.len = 48'($urandom_range(1, 16));
            end
            5: begin
              s.ofs = 48'({$urandom, $urandom}) >> $urandom_range(0, 47);
              s.len = 48'd1 << $urandom_range(0, 47);
            end
            6: begin
              s.ofs = '1 - 48'($urandom_range(0, 1000));
              s.len = 48'({$urandom, $urandom});
            end
            default: begin
              s.ofs = 48'({$urandom, $urandom});
              s.len = '0;
            end
          endcase
          add_span(s.ofs, s.len);
          n++;
        end
      end
      drain();
    end

    repeat (80) @(posedge clk);
    $display("%0d spans mapped under %0d register settings: %0d chunks, %0d weight errors",
             beats_in, setups, chunks_out, weight_errs_out);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/wsm_pkg.sv
rtl/wsm_ctrl.sv
rtl/wsm_dp.sv
rtl/weighted_stripe_mapper.sv
tb/weighted_stripe_mapper_tb.sv
